[hw/rtl/xmodem_checksum_receiver_assert.svh]
// ----------------------------------------------------------------------------
// XMODEM checksum receiver assertion macros
// Shorthand for the concurrent checks used by the receiver's checker.
// ----------------------------------------------------------------------------
`ifndef XMODEM_CHECKSUM_RECEIVER_ASSERT_SVH
`define XMODEM_CHECKSUM_RECEIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XCR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XCR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/xcr_pkg.sv]
// ----------------------------------------------------------------------------
// XMODEM checksum receiver package
// Beat types, protocol bytes, codes and a helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package xcr_pkg;

   localparam int unsigned PACKET_BYTES = 128;
   localparam int unsigned BYTE_INDEX_W = $clog2(PACKET_BYTES + 1);

   // Protocol bytes
   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_SUB = 8'h1a;
   localparam logic [7:0] BYTE_ESC = 8'h1b;

   localparam logic [15:0] INTERVAL_RESET = 16'd1000;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      END_EOT      = 2'd0,
      END_CANCEL   = 2'd1,
      END_ESCAPE   = 2'd2,
      END_PROTOCOL = 2'd3
   } end_status_type;

   typedef enum logic [1:0] {
      CSR_BASE_ADDRESS  = 2'd0,
      CSR_VERIFY_MODE   = 2'd1,
      CSR_SYNC_INTERVAL = 2'd2,
      CSR_BYTE_TIMEOUT  = 2'd3
   } csr_index_type;

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_SYNC   = 8'b0000_0010,
      PH_HEADER = 8'b0000_0100,
      PH_SEQ1   = 8'b0000_1000,
      PH_SEQ2   = 8'b0001_0000,
      PH_DATA   = 8'b0010_0000,
      PH_CSUM   = 8'b0100_0000,
      PH_DONE   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
      logic [7:0] stored_byte;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        mem_write;
      logic [31:0] mem_addr;
      logic [7:0]  mem_data;
      logic        done_res;
      logic [1:0]  end_status;
      logic [31:0] packet_count;
      logic [31:0] byte_total;
      logic [31:0] mismatch_count;
      logic [31:0] first_mismatch_addr;
   } rsp_type;

   // Saturating 32-bit add: the carry out selects all ones.
   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hffff_ffff : sum[31:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/xmodem_checksum_receiver.sv]
// ----------------------------------------------------------------------------
// XMODEM checksum receiver
// Receiver side of XMODEM with 128-byte packets and an 8-bit checksum.
// ----------------------------------------------------------------------------
//   channel   direction   handshake            beat
//   req_      in          req_valid/req_stall  opcode, rx_byte, stored_byte
//   rsp_      out         rsp_valid/rsp_stall  reply, memory access, status
//   csr_      in          csr_wr_en            index and data, write only
//
// One beat is accepted per cycle while req_stall is low; each produces exactly one
// result beat, which passes the input register, then the result register.
// The whole update of one event sits between those two registers.
// With rsp_stall high, one further beat is still taken into the input register.
// Reset is synchronous and restores the configuration, valid flags and session state.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_checksum_receiver (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire xcr_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output xcr_pkg::rsp_type     rsp_payload,
   input  wire logic            csr_wr_en,
   input  wire logic [1:0]      csr_index,
   input  wire logic [31:0]     csr_wdata
);

   import xcr_pkg::*;

   // Configuration
   logic [31:0] base_address_ff;
   logic        verify_mode_ff;
   logic [15:0] sync_interval_ff;
   logic [15:0] byte_timeout_ff;

   // Pipeline
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff, out_item_in;
   logic    advance;

   // Session state
   phase_type               phase_ff, phase_in;
   logic [7:0]              expected_seq_ff, expected_seq_in;
   logic [7:0]              seq_first_ff, seq_first_in;
   logic [7:0]              seq_second_ff, seq_second_in;
   logic [BYTE_INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]              running_sum_ff, running_sum_in;
   logic [31:0]             data_address_ff, data_address_in;
   logic [15:0]             tick_count_ff, tick_count_in;
   logic [31:0]             packets_ff, packets_in;
   logic [31:0]             bytes_ff, bytes_in;
   logic [31:0]             mismatches_ff, mismatches_in;
   logic [31:0]             first_mismatch_ff, first_mismatch_in;

   logic [BYTE_INDEX_W-1:0] byte_index_inc;
   logic [15:0]             tick_inc;
   logic [31:0]             cur_addr;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   assign byte_index_inc = byte_index_ff + 1'b1;
   assign tick_inc       = tick_count_ff + 16'd1;
   assign cur_addr       = data_address_ff + 32'(byte_index_ff);

   always_comb begin
      phase_in          = phase_ff;
      expected_seq_in   = expected_seq_ff;
      seq_first_in      = seq_first_ff;
      seq_second_in     = seq_second_ff;
      byte_index_in     = byte_index_ff;
      running_sum_in    = running_sum_ff;
      data_address_in   = data_address_ff;
      tick_count_in     = tick_count_ff;
      packets_in        = packets_ff;
      bytes_in          = bytes_ff;
      mismatches_in     = mismatches_ff;
      first_mismatch_in = first_mismatch_ff;

      out_item_in            = '0;
      out_item_in.mem_addr   = cur_addr;

      case (opcode_type'(in_item_ff.opcode))
         OP_START: begin
            phase_in          = PH_SYNC;
            expected_seq_in   = 8'd1;
            seq_first_in      = '0;
            seq_second_in     = '0;
            byte_index_in     = '0;
            running_sum_in    = '0;
            data_address_in   = base_address_ff;
            tick_count_in     = '0;
            packets_in        = '0;
            bytes_in          = '0;
            mismatches_in     = '0;
            first_mismatch_in = '0;
            out_item_in.tx_valid = 1'b1;
            out_item_in.tx_byte  = BYTE_NAK;
         end
         OP_TICK: begin
            case (phase_ff)
               PH_SYNC: begin
                  tick_count_in = tick_inc;
                  if (tick_inc >= sync_interval_ff) begin
                     tick_count_in        = '0;
                     out_item_in.tx_valid = 1'b1;
                     out_item_in.tx_byte  = BYTE_NAK;
                  end
               end
               PH_SEQ1, PH_SEQ2, PH_DATA: begin
                  tick_count_in = tick_inc;
                  if (tick_inc >= byte_timeout_ff) begin
                     tick_count_in        = '0;
                     phase_in             = PH_HEADER;
                     out_item_in.tx_valid = 1'b1;
                     out_item_in.tx_byte  = BYTE_NAK;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_BYTE: begin
            case (phase_ff)
               PH_SYNC, PH_HEADER: begin
                  tick_count_in = '0;
                  case (in_item_ff.rx_byte)
                     BYTE_SOH: begin
                        phase_in       = PH_SEQ1;
                        byte_index_in  = '0;
                        running_sum_in = '0;
                     end
                     BYTE_EOT: begin
                        phase_in             = PH_DONE;
                        out_item_in.tx_valid = 1'b1;
                        out_item_in.tx_byte  = BYTE_ACK;
                        out_item_in.done_res = 1'b1;
                        out_item_in.end_status = END_EOT;
                     end
                     BYTE_CAN: begin
                        phase_in               = PH_DONE;
                        out_item_in.done_res   = 1'b1;
                        out_item_in.end_status = END_CANCEL;
                     end
                     BYTE_ESC: begin
                        phase_in               = PH_DONE;
                        out_item_in.done_res   = 1'b1;
                        out_item_in.end_status = END_ESCAPE;
                     end
                     BYTE_SUB: begin
                        phase_in = PH_HEADER;
                     end
                     default: begin
                        phase_in               = PH_DONE;
                        out_item_in.done_res   = 1'b1;
                        out_item_in.end_status = END_PROTOCOL;
                     end
                  endcase
               end
               PH_SEQ1: begin
                  seq_first_in  = in_item_ff.rx_byte;
                  tick_count_in = '0;
                  phase_in      = PH_SEQ2;
               end
               PH_SEQ2: begin
                  seq_second_in = in_item_ff.rx_byte;
                  tick_count_in = '0;
                  phase_in      = PH_DATA;
               end
               PH_DATA: begin
                  tick_count_in        = '0;
                  out_item_in.mem_data = in_item_ff.rx_byte;
                  if (verify_mode_ff) begin
                     if (in_item_ff.stored_byte != in_item_ff.rx_byte) begin
                        if (mismatches_ff == '0) begin
                           first_mismatch_in = cur_addr;
                        end
                        mismatches_in = sat_add32(mismatches_ff, 32'd1);
                     end
                  end else begin
                     out_item_in.mem_write = 1'b1;
                  end
                  running_sum_in = running_sum_ff + in_item_ff.rx_byte;
                  byte_index_in  = byte_index_inc;
                  if (byte_index_inc >= BYTE_INDEX_W'(PACKET_BYTES)) begin
                     phase_in = PH_CSUM;
                  end
               end
               PH_CSUM: begin
                  out_item_in.tx_valid = 1'b1;
                  phase_in             = PH_HEADER;
                  byte_index_in        = '0;
                  running_sum_in       = '0;
                  // Checksum, then complement, then sequence number.
                  if (running_sum_ff != in_item_ff.rx_byte) begin
                     out_item_in.tx_byte = BYTE_NAK;
                  end else if (seq_first_ff != ~seq_second_ff) begin
                     out_item_in.tx_byte = BYTE_NAK;
                  end else if (seq_first_ff == expected_seq_ff) begin
                     data_address_in     = data_address_ff + 32'(PACKET_BYTES);
                     expected_seq_in     = expected_seq_ff + 8'd1;
                     packets_in          = sat_add32(packets_ff, 32'd1);
                     bytes_in            = sat_add32(bytes_ff, 32'(PACKET_BYTES));
                     out_item_in.tx_byte = BYTE_ACK;
                  end else if (seq_first_ff == expected_seq_ff - 8'd1) begin
                     // A repeat of the last packet is acknowledged but not taken.
                     out_item_in.tx_byte = BYTE_ACK;
                  end else begin
                     out_item_in.tx_byte    = BYTE_CAN;
                     out_item_in.done_res   = 1'b1;
                     out_item_in.end_status = END_PROTOCOL;
                     phase_in               = PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      out_item_in.packet_count        = packets_in;
      out_item_in.byte_total          = bytes_in;
      out_item_in.mismatch_count      = mismatches_in;
      out_item_in.first_mismatch_addr = first_mismatch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff  <= '0;
         verify_mode_ff   <= 1'b0;
         sync_interval_ff <= INTERVAL_RESET;
         byte_timeout_ff  <= INTERVAL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_ADDRESS:  base_address_ff  <= csr_wdata;
            CSR_VERIFY_MODE:   verify_mode_ff   <= csr_wdata[0];
            CSR_SYNC_INTERVAL: sync_interval_ff <= csr_wdata[15:0];
            CSR_BYTE_TIMEOUT:  byte_timeout_ff  <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         phase_ff          <= PH_IDLE;
         expected_seq_ff   <= 8'd1;
         seq_first_ff      <= '0;
         seq_second_ff     <= '0;
         byte_index_ff     <= '0;
         running_sum_ff    <= '0;
         data_address_ff   <= '0;
         tick_count_ff     <= '0;
         packets_ff        <= '0;
         bytes_ff          <= '0;
         mismatches_ff     <= '0;
         first_mismatch_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff          <= phase_in;
            expected_seq_ff   <= expected_seq_in;
            seq_first_ff      <= seq_first_in;
            seq_second_ff     <= seq_second_in;
            byte_index_ff     <= byte_index_in;
            running_sum_ff    <= running_sum_in;
            data_address_ff   <= data_address_in;
            tick_count_ff     <= tick_count_in;
            packets_ff        <= packets_in;
            bytes_ff          <= bytes_in;
            mismatches_ff     <= mismatches_in;
            first_mismatch_ff <= first_mismatch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/xcr_checker.sv]
// ----------------------------------------------------------------------------
// XMODEM checksum receiver checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xmodem_checksum_receiver_assert.svh"

module xcr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire xcr_pkg::rsp_type rsp_payload
);

   import xcr_pkg::*;

   `XCR_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload),
      "stalled result beat changed")

   `XCR_ASSERT_SAME(a_tx_code, clock, reset,
      rsp_valid && rsp_payload.tx_valid,
      rsp_payload.tx_byte == BYTE_NAK || rsp_payload.tx_byte == BYTE_ACK ||
      rsp_payload.tx_byte == BYTE_CAN,
      "reply byte is not NAK, ACK or CAN")

   `XCR_ASSERT_SAME(a_tx_quiet, clock, reset,
      rsp_valid && !rsp_payload.tx_valid, rsp_payload.tx_byte == 8'h00,
      "reply byte set without a reply")

   `XCR_ASSERT_SAME(a_status_idle, clock, reset,
      rsp_valid && !rsp_payload.done_res, rsp_payload.end_status == END_EOT,
      "end status set while the session runs")

   `XCR_ASSERT_SAME(a_write_alone, clock, reset,
      rsp_valid && rsp_payload.mem_write, !rsp_payload.tx_valid && !rsp_payload.done_res,
      "data write coincides with a reply or session end")

endmodule

bind xmodem_checksum_receiver xcr_checker u_xcr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
